@@ hdl/assert_macros.svh @@
// assertion macros used by the datapath rtl file, ilms_dp
// no dependencies; simulation gets the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent true implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed")

// antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed")

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/ilms_pkg.sv @@
// shared types and constants of the input latency measurement sequencer
// no dependencies; used by every module of the block
`default_nettype none

package ilms_pkg;

    // timestamp and accumulator widths
    localparam int TIME_W   = 48;
    localparam int TOTAL_W  = 48;
    localparam int ACC_W    = ((TIME_W > TOTAL_W) ? TIME_W : TOTAL_W) + 1;
    localparam int DIV_CNT_W = $clog2(TOTAL_W);

    // field widths
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 16;
    localparam int BASE_W    = 20;
    localparam int TIMEOUT_W = 24;
    localparam int CORR_W    = 16;
    localparam int OFFSET_W  = 10;
    localparam int LAT_W     = 25;
    localparam int AVG_W     = 24;
    localparam int ADD_W     = 21;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // stream word widths, padded to whole bytes
    localparam int IN_W  = ((CMD_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_BITS = 3 + OFFSET_W + 1 + LAT_W + 1 + 1 + AVG_W + 1 + COUNT_W;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INPUT      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONNECT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_DELAY   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DROP_TIMEOUT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_CORR   = 2'd3;

    // register reset values
    localparam logic [COUNT_W-1:0]   RST_SAMPLE_COUNT = 16'd3000;
    localparam logic [BASE_W-1:0]    RST_BASE_DELAY   = 20'd10000;
    localparam logic [TIMEOUT_W-1:0] RST_DROP_TIMEOUT = 24'd500000;
    localparam logic [CORR_W-1:0]    RST_FRAME_CORR   = 16'd1000;

    // reciprocal constants for remainder by 1000 and by 10 of a 16 bit value
    localparam logic [32:0] RECIP_1000 = 33'd67109;
    localparam int          SHIFT_1000 = 26;
    localparam logic [32:0] RECIP_10   = 33'd52429;
    localparam int          SHIFT_10   = 19;

    // latency clamping
    localparam logic [30:0]        EL_CAP  = 31'h4000_0000;
    localparam logic signed [32:0] LAT_MIN = -33'sd65535;
    localparam logic signed [32:0] LAT_MAX = 33'sd16777215;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic apply_cmd;
        logic sched_dec;
        logic mod_mul;
        logic mod_sub;
        logic sum;
        logic ttime;
        logic toggle;
        logic elapsed;
        logic input_acc;
        logic lat_calc;
        logic div_start;
        logic div_store;
        logic drop;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sched_ok;
        logic tog_ok;
        logic input_ok;
        logic last_sample;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/ilms_div.sv @@
// radix-2 restoring divider for the end-of-run average
// depends on ilms_pkg
`default_nettype none

module ilms_div
    import ilms_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [TOTAL_W-1:0] dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output logic                    done,
    output logic [TOTAL_W-1:0]      quotient
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(TOTAL_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic [TOTAL_W-1:0]   q_reg;
    logic [COUNT_W-1:0]   d_reg;
    logic [COUNT_W:0]     rem_sh;
    logic                 ge;

    always_comb begin
        rem_sh   = {rem_reg, q_reg[TOTAL_W-1]};
        ge       = (rem_sh >= {1'b0, d_reg});
        rem_next = ge ? COUNT_W'(rem_sh - {1'b0, d_reg}) : rem_sh[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[TOTAL_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

@@ hdl/ilms_ctrl.sv @@
// sequencing state machine: walks one word through the datapath steps
// depends on ilms_pkg
`default_nettype none

module ilms_ctrl
    import ilms_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCHED,
        ST_MOD_MUL,
        ST_MOD_SUB,
        ST_SUM,
        ST_TTIME,
        ST_TOG,
        ST_ELAPSED,
        ST_INPUT,
        ST_LAT,
        ST_DIV_WAIT,
        ST_DROP,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) state_next = ST_CMD;
            end
            ST_CMD: begin
                cmd.apply_cmd = 1'b1;
                state_next    = ST_SCHED;
            end
            ST_SCHED: begin
                cmd.sched_dec = stat.sched_ok;
                state_next    = stat.sched_ok ? ST_MOD_MUL : ST_TOG;
            end
            ST_MOD_MUL: begin
                cmd.mod_mul = 1'b1;
                state_next  = ST_MOD_SUB;
            end
            ST_MOD_SUB: begin
                cmd.mod_sub = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_TTIME;
            end
            ST_TTIME: begin
                cmd.ttime  = 1'b1;
                state_next = ST_TOG;
            end
            ST_TOG: begin
                cmd.toggle = stat.tog_ok;
                state_next = ST_ELAPSED;
            end
            ST_ELAPSED: begin
                cmd.elapsed = 1'b1;
                state_next  = ST_INPUT;
            end
            ST_INPUT: begin
                cmd.input_acc = stat.input_ok;
                state_next    = stat.input_ok ? ST_LAT : ST_DROP;
            end
            ST_LAT: begin
                cmd.lat_calc  = 1'b1;
                cmd.div_start = stat.last_sample;
                state_next    = stat.last_sample ? ST_DIV_WAIT : ST_DROP;
            end
            ST_DIV_WAIT: begin
                cmd.div_store = stat.div_done;
                if (stat.div_done) state_next = ST_DROP;
            end
            ST_DROP: begin
                cmd.drop   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/ilms_dp.sv @@
// datapath: run state, scheduling arithmetic, latency and average results
// depends on ilms_pkg, ilms_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ilms_dp
    import ilms_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [IN_W-1:0]       s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat
);

    // configuration registers
    logic [COUNT_W-1:0]   sample_count_reg;
    logic [BASE_W-1:0]    base_delay_reg;
    logic [TIMEOUT_W-1:0] drop_timeout_reg;
    logic [CORR_W-1:0]    frame_corr_reg;

    // captured word
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [TIME_W-1:0] now_reg;

    // run state
    logic                connected_reg;
    logic [COUNT_W-1:0]  remaining_reg;
    logic                pending_reg;
    logic                awaiting_reg;
    logic                seen_reg;
    logic [TIME_W-1:0]   toggle_time_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                pin_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                led_reg;

    // working registers
    logic [32:0]       prod1000_reg;
    logic [32:0]       prod10_reg;
    logic [3:0]        m10_reg;
    logic [ADD_W-1:0]  add_reg;
    logic [TIME_W-1:0] el_reg;

    // per-word result fields
    logic             res_tog_reg;
    logic             res_sched_reg;
    logic             res_sval_reg;
    logic [LAT_W-1:0] res_lat_reg;
    logic             res_drop_reg;
    logic             res_aval_reg;
    logic [AVG_W-1:0] res_avg_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    // combinational helpers
    logic [COUNT_W-1:0] q1000_c;
    logic [COUNT_W-1:0] q10_c;
    logic [COUNT_W-1:0] off_wide_c;
    logic [COUNT_W-1:0] m10_wide_c;
    logic [TIME_W:0]    tsum_c;
    logic [ACC_W-1:0]   acc_c;
    logic [30:0]        el_cap_c;
    logic signed [32:0] lat_c;
    logic [LAT_W-1:0]   lat_sat_c;
    logic [COUNT_W-1:0] divisor_c;
    logic               div_done;
    logic [TOTAL_W-1:0] div_q;

    always_comb begin
        q1000_c    = COUNT_W'(prod1000_reg >> SHIFT_1000);
        q10_c      = COUNT_W'(prod10_reg >> SHIFT_10);
        off_wide_c = remaining_reg - COUNT_W'(q1000_c * 16'd1000);
        m10_wide_c = remaining_reg - COUNT_W'(q10_c * 16'd10);
        tsum_c     = {1'b0, now_reg} + (TIME_W+1)'(add_reg);
        acc_c      = ACC_W'(total_reg) + ACC_W'(el_reg);
        el_cap_c   = (el_reg > TIME_W'(EL_CAP)) ? EL_CAP : el_reg[30:0];
        lat_c      = $signed({2'b00, el_cap_c}) - $signed({17'd0, frame_corr_reg})
                   + $signed({23'd0, offset_reg});
        if (lat_c < LAT_MIN) begin
            lat_sat_c = LAT_W'(LAT_MIN);
        end else if (lat_c > LAT_MAX) begin
            lat_sat_c = LAT_W'(LAT_MAX);
        end else begin
            lat_sat_c = lat_c[LAT_W-1:0];
        end
        divisor_c = (sample_count_reg == '0) ? COUNT_W'(1) : sample_count_reg;
    end

    always_comb begin
        stat.sched_ok    = (in_cmd_reg == CMD_FRAME) && connected_reg
                         && (remaining_reg != '0) && !awaiting_reg && !pending_reg;
        stat.tog_ok      = pending_reg && (now_reg > toggle_time_reg);
        stat.input_ok    = awaiting_reg && seen_reg;
        stat.last_sample = (remaining_reg == '0);
        stat.div_done    = div_done;
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    ilms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (divisor_c),
        .done     (div_done),
        .quotient (div_q)
    );

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= RST_SAMPLE_COUNT;
            base_delay_reg   <= RST_BASE_DELAY;
            drop_timeout_reg <= RST_DROP_TIMEOUT;
            frame_corr_reg   <= RST_FRAME_CORR;
            connected_reg    <= 1'b0;
            remaining_reg    <= '0;
            pending_reg      <= 1'b0;
            awaiting_reg     <= 1'b0;
            seen_reg         <= 1'b0;
            toggle_time_reg  <= '0;
            offset_reg       <= '0;
            pin_reg          <= 1'b1;
            total_reg        <= '0;
            led_reg          <= 1'b0;
            res_tog_reg      <= 1'b0;
            res_sched_reg    <= 1'b0;
            res_sval_reg     <= 1'b0;
            res_drop_reg     <= 1'b0;
            res_aval_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[COUNT_W-1:0];
                    CFG_BASE_DELAY:   base_delay_reg   <= cfg_wdata[BASE_W-1:0];
                    CFG_DROP_TIMEOUT: drop_timeout_reg <= cfg_wdata[TIMEOUT_W-1:0];
                    CFG_FRAME_CORR:   frame_corr_reg   <= cfg_wdata[CORR_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.load_in) begin
                res_tog_reg   <= 1'b0;
                res_sched_reg <= 1'b0;
                res_sval_reg  <= 1'b0;
                res_drop_reg  <= 1'b0;
                res_aval_reg  <= 1'b0;
            end

            if (cmd.apply_cmd) begin
                case (in_cmd_reg)
                    CMD_INPUT: begin
                        seen_reg <= 1'b1;
                    end
                    CMD_CONNECT: begin
                        total_reg     <= '0;
                        remaining_reg <= sample_count_reg;
                        connected_reg <= 1'b1;
                        led_reg       <= 1'b1;
                    end
                    CMD_DISCONNECT: begin
                        connected_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (cmd.sched_dec) begin
                remaining_reg <= remaining_reg - 1'b1;
                if (remaining_reg == COUNT_W'(1)) led_reg <= 1'b0;
                res_sched_reg <= 1'b1;
            end

            if (cmd.mod_sub) begin
                offset_reg <= off_wide_c[OFFSET_W-1:0];
            end

            if (cmd.ttime) begin
                toggle_time_reg <= tsum_c[TIME_W] ? '1 : tsum_c[TIME_W-1:0];
                pending_reg     <= 1'b1;
            end

            if (cmd.toggle) begin
                pin_reg      <= ~pin_reg;
                pending_reg  <= 1'b0;
                awaiting_reg <= 1'b1;
                seen_reg     <= 1'b0;
                res_tog_reg  <= 1'b1;
            end

            if (cmd.input_acc) begin
                total_reg    <= (acc_c[ACC_W-1:TOTAL_W] != '0) ? '1 : acc_c[TOTAL_W-1:0];
                awaiting_reg <= 1'b0;
                seen_reg     <= 1'b0;
                res_sval_reg <= 1'b1;
            end

            if (cmd.div_store) begin
                res_aval_reg <= 1'b1;
            end

            if (cmd.drop && awaiting_reg && (el_reg > TIME_W'(drop_timeout_reg))) begin
                awaiting_reg <= 1'b0;
                res_drop_reg <= 1'b1;
            end

            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_cmd_reg  <= s_tdata[CMD_W-1:0];
            now_reg     <= s_tdata[CMD_W +: TIME_W];
            res_lat_reg <= '0;
            res_avg_reg <= '0;
        end
        if (cmd.mod_mul) begin
            prod1000_reg <= 33'(remaining_reg) * RECIP_1000;
            prod10_reg   <= 33'(remaining_reg) * RECIP_10;
        end
        if (cmd.mod_sub) begin
            m10_reg <= m10_wide_c[3:0];
        end
        if (cmd.sum) begin
            add_reg <= ADD_W'(base_delay_reg) + ADD_W'(m10_reg) * 21'd1000
                     + ADD_W'(offset_reg);
        end
        if (cmd.elapsed) begin
            el_reg <= (now_reg > toggle_time_reg) ? (now_reg - toggle_time_reg) : '0;
        end
        if (cmd.lat_calc) begin
            res_lat_reg <= lat_sat_c;
        end
        if (cmd.div_store) begin
            res_avg_reg <= (div_q[TOTAL_W-1:AVG_W] != '0) ? '1 : div_q[AVG_W-1:0];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_W'({remaining_reg, led_reg, res_avg_reg, res_aval_reg,
                                   res_drop_reg, res_lat_reg, res_sval_reg, offset_reg,
                                   res_sched_reg, res_tog_reg, pin_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_IMPLIES(a_pending_excl, aclk, aresetn, pending_reg, !awaiting_reg);
    `ASSERT_IMPLIES(a_sched_leaves_work, aclk, aresetn, cmd.out_load && res_sched_reg,
                    pending_reg || res_tog_reg);
    `ASSERT_IMPLIES(a_drop_not_sample, aclk, aresetn, cmd.out_load && res_drop_reg,
                    !res_sval_reg);
    `ASSERT_IMPLIES(a_avg_with_sample, aclk, aresetn, cmd.out_load && res_aval_reg,
                    res_sval_reg && (remaining_reg == '0));
    `ASSERT_NEXT(a_out_loaded, aclk, aresetn, cmd.out_load, m_tvalid_reg);

endmodule

`default_nettype wire

@@ hdl/input_latency_measurement_sequencer.sv @@
// a word is taken only after the previous one has walked its controller steps;
// a frame start that schedules a toggle adds the modulo, sum and toggle time steps,
// a reported sample adds the latency step; the last sample of a run also waits on the
// radix-2 average divider, which makes one quotient bit per cycle over the 48 bit total
// the result register lets the next word in while a result waits on m_tready
// reset: synchronous, active low; control and configuration registers return to their defaults, no run active
`default_nettype none

module input_latency_measurement_sequencer
    import ilms_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // register writes: 0 sample_count, 1 base_delay_us, 2 drop_timeout_us,
    // 3 frame_correction_us
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,  // command[2:0], time_us[50:3]

    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // button_level[0], toggled[1], scheduled[2], frame_offset_us[12:3],
    // sample_valid[13], latency_us[38:14], dropped[39], average_valid[40],
    // average_us[64:41], led_on[65], samples_remaining[81:66]
    output logic [OUT_W-1:0]           m_tdata
);

    // command and status between the sequencer and the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: one word at a time, in model order: command, schedule,
    // toggle, input change, average, timeout, then the result register
    ilms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: run state, toggle time arithmetic, latency clamping, divider
    ilms_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
